// ===== hdl/dpqs_pkg.sv =====
// Shared types and constants for the dual-policy ready-queue scheduler.
`timescale 1ns / 1ps

package dpqs_pkg;

  localparam int LIST_DEPTH  = 32;
  localparam int LEVEL_COUNT = 5;
  localparam int LEVEL_REGS  = 5;
  localparam int NUM_LEVELS  = (LEVEL_COUNT < LEVEL_REGS) ? LEVEL_COUNT : LEVEL_REGS;
  localparam int NO_LEVEL    = LEVEL_REGS;

  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int LVL_W      = $clog2(NO_LEVEL + 1);
  localparam int ID_W       = 8;
  localparam int PRIO_W     = 8;
  localparam int DATA_W     = ID_W + PRIO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic {
    CMD_RUNNABLE = 1'b0,
    CMD_PICK     = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_FULL     = 2'd1,
    ST_PICKED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    POLICY_PRIO  = 1'b0,
    POLICY_LEVEL = 1'b1
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 3'd0,
    CFG_LEVEL0 = 3'd1,
    CFG_LEVEL1 = 3'd2,
    CFG_LEVEL2 = 3'd3,
    CFG_LEVEL3 = 3'd4,
    CFG_LEVEL4 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   thread;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_load;
    logic    scan_start;
    logic    scan_issue;
    logic    shift_start;
    logic    shift_issue;
    logic    append_write;
    logic    count_dec;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_pick;
    logic full;
    logic ptr_end;
    logic found;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/dpqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dpqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dpqs_ctrl.sv =====
// Controller state machine that sequences append, scan, compaction and result.
`timescale 1ns / 1ps

module dpqs_ctrl import dpqs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t res_status;
  status_t res_status_next;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = '0;
    cmd.out_status  = res_status;
    in_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load    = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = st.in_pick ? S_SCAN : S_APPEND;
        end
      end
      S_APPEND: begin
        if (st.full) begin
          res_status_next = ST_FULL;
        end else begin
          cmd.append_write = 1'b1;
          res_status_next  = ST_APPENDED;
        end
        state_next = S_RESULT;
      end
      S_SCAN: begin
        // The last read is evaluated at the edge that leaves this state.
        if (st.ptr_end) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_DECIDE: begin
        if (!st.found) begin
          res_status_next = ST_EMPTY;
          state_next      = S_RESULT;
        end else begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (st.ptr_end) begin
          cmd.count_dec   = 1'b1;
          res_status_next = ST_PICKED;
          state_next      = S_RESULT;
        end else begin
          cmd.shift_issue = 1'b1;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_APPENDED;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

// ===== hdl/dpqs_datapath.sv =====
// Datapath: registers, ready-list memory, scan selection, compaction and output register.
`timescale 1ns / 1ps

module dpqs_datapath import dpqs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_cmd,
  input  logic [ID_W-1:0]       in_id,
  input  logic [PRIO_W-1:0]     in_prio,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output status_t               out_status,
  output logic [ID_W-1:0]       out_id,
  output logic [PRIO_W-1:0]     out_prio,
  input  dp_cmd_t               cmd,
  output dp_status_t            st
);

  policy_t             policy;
  logic [PRIO_W-1:0]   level_prio [LEVEL_REGS];

  logic [ID_W-1:0]     item_id;
  logic [PRIO_W-1:0]   item_prio;
  logic [LVL_W-1:0]    new_level;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;
  logic                mode_shift;
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;

  logic                found;
  logic [IDX_W-1:0]    sel;
  logic [ID_W-1:0]     best_id;
  logic [PRIO_W-1:0]   best_prio;
  logic [LVL_W-1:0]    best_level;
  logic                take;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;
  entry_t              new_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POLICY_PRIO;
      level_prio[0] <= PRIO_W'(10);
      level_prio[1] <= PRIO_W'(5);
      level_prio[2] <= PRIO_W'(2);
      level_prio[3] <= PRIO_W'(1);
      level_prio[4] <= PRIO_W'(0);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POLICY: policy        <= policy_t'(cfg_data[0]);
        CFG_LEVEL0: level_prio[0] <= cfg_data;
        CFG_LEVEL1: level_prio[1] <= cfg_data;
        CFG_LEVEL2: level_prio[2] <= cfg_data;
        CFG_LEVEL3: level_prio[3] <= cfg_data;
        CFG_LEVEL4: level_prio[4] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Lowest-numbered matching level wins; no match tags the entry as levelless.
  always_comb begin
    new_level = LVL_W'(NO_LEVEL);
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (level_prio[i] == item_prio) begin
        new_level = LVL_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      item_id   <= in_id;
      item_prio <= in_prio;
    end
  end

  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    if (policy == POLICY_PRIO) begin
      take = !found || (rd_entry.prio > best_prio);
    end else begin
      take = (rd_entry.level < LVL_W'(NO_LEVEL)) && (!found || (rd_entry.level < best_level));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ptr        <= '0;
      mode_shift <= 1'b0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
    end else begin
      rd_vld <= ram_re;
      if (cmd.append_write) begin
        count <= count + CNT_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.scan_start) begin
        ptr        <= '0;
        mode_shift <= 1'b0;
        found      <= 1'b0;
      end else if (cmd.shift_start) begin
        ptr        <= CNT_W'(sel) + CNT_W'(1);
        mode_shift <= 1'b1;
      end else if (ram_re) begin
        ptr <= ptr + CNT_W'(1);
      end
      if (rd_vld && !mode_shift && take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx <= ptr[IDX_W-1:0];
    end
    if (rd_vld && !mode_shift && take) begin
      sel        <= rd_idx;
      best_id    <= rd_entry.thread;
      best_prio  <= rd_entry.prio;
      best_level <= rd_entry.level;
    end
  end

  assign new_entry.level  = new_level;
  assign new_entry.prio   = item_prio;
  assign new_entry.thread = item_id;

  // Compaction reads one slot ahead and writes it back one slot lower.
  assign ram_re    = cmd.scan_issue || cmd.shift_issue;
  assign ram_we    = cmd.append_write || (rd_vld && mode_shift);
  assign ram_waddr = cmd.append_write ? count[IDX_W-1:0] : (rd_idx - IDX_W'(1));
  assign ram_wdata = cmd.append_write ? new_entry : ram_rdata;

  dpqs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      if (cmd.out_status == ST_PICKED) begin
        out_id   <= best_id;
        out_prio <= best_prio;
      end else begin
        out_id   <= '0;
        out_prio <= '0;
      end
    end
  end

  assign st.in_pick  = (cmd_t'(in_cmd) == CMD_PICK);
  assign st.full     = (count == CNT_W'(LIST_DEPTH));
  assign st.ptr_end  = (ptr == count);
  assign st.found    = found;
  assign st.out_free = !out_valid || out_ready;

endmodule

// ===== hdl/dual_policy_ready_queue_scheduler.sv =====
// Top level of the dual-policy ready-queue scheduler.
//
//   channel   direction  handshake               payload
//   s_axis    in         s_axis_tvalid/tready    tuser: command; tdata: thread_id, thread_priority
//   m_axis    out        m_axis_tvalid/tready    tuser: status; tdata: picked_id, picked_priority
//   cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One transaction is handled at a time. An append passes S_APPEND and S_RESULT on its
// way to the result register. A pick is paced by the single read port of the list
// memory: a scan pass over the whole list, then a compaction pass that moves each later
// entry down one slot.
// rst is synchronous; it clears the list count, the registers and the output valid.
// A result held by m_axis_tready low stalls the next transaction before its result loads.
`timescale 1ns / 1ps

module dual_policy_ready_queue_scheduler import dpqs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,   // [7:0] thread_id, [15:8] thread_priority
  input  logic                  s_axis_tuser,   // [0] command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_W-1:0]     m_axis_tdata,   // [7:0] picked_id, [15:8] picked_priority
  output logic [1:0]            m_axis_tuser,   // [1:0] status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t           cmd;
  dp_status_t        st;
  status_t           out_status;
  logic [ID_W-1:0]   out_id;
  logic [PRIO_W-1:0] out_prio;

  assign cfg_ready = 1'b1;

  dpqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dpqs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_axis_tuser),
    .in_id      (s_axis_tdata[ID_W-1:0]),
    .in_prio    (s_axis_tdata[DATA_W-1:ID_W]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_id     (out_id),
    .out_prio   (out_prio),
    .cmd        (cmd),
    .st         (st)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {out_prio, out_id};

endmodule

// ===== hdl/dpqs_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps

module dpqs_checker import dpqs_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [DATA_W-1:0]     m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  // Only one transaction is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous transaction still in work");

  // Only a picked result carries a thread.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_PICKED)) |-> (m_axis_tdata == '0))
    else $error("non-pick result carries nonzero payload");

  // A result appears only after the block stopped taking input to work on it.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a transaction in work");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind dual_policy_ready_queue_scheduler dpqs_checker u_dpqs_checker (.*);

// ===== verif/tb_dual_policy_ready_queue_scheduler.sv =====
// Self-checking testbench for the dual-policy ready-queue scheduler.
`timescale 1ns / 1ps

module tb_dual_policy_ready_queue_scheduler;
  import dpqs_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int END_SETTLE   = 2 * LIST_DEPTH + 16;

  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } sched_result_t;

  typedef struct {
    policy_t           pol;
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    status_t           exp_status;
    logic [ID_W-1:0]   exp_id;
    logic [PRIO_W-1:0] exp_prio;
  } directed_row_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dual_policy_ready_queue_scheduler uut (.*);

  always #1 clk = ~clk;

  // Shadow copy of the ready list and the registers.
  logic [ID_W-1:0]   ready_id   [LIST_DEPTH];
  logic [PRIO_W-1:0] ready_prio [LIST_DEPTH];
  int                ready_lvl  [LIST_DEPTH];
  int                ready_cnt = 0;
  policy_t           sched_policy = POLICY_PRIO;
  logic [PRIO_W-1:0] level_value [LEVEL_REGS] = '{8'd10, 8'd5, 8'd2, 8'd1, 8'd0};

  sched_result_t expected_results[$];
  int            mismatch_count = 0;

  function automatic sched_result_t predict_schedule(cmd_t cmd, logic [ID_W-1:0] tid,
                                                     logic [PRIO_W-1:0] tpri);
    sched_result_t res;
    int sel;
    int lvl;
    bit found;
    res = '{ST_APPENDED, '0, '0};
    sel = 0;
    found = 1'b0;
    if (cmd == CMD_RUNNABLE) begin
      if (ready_cnt >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // The lowest-numbered matching level wins.
        lvl = NO_LEVEL;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
          if (level_value[i] == tpri) lvl = i;
        ready_id[ready_cnt]   = tid;
        ready_prio[ready_cnt] = tpri;
        ready_lvl[ready_cnt]  = lvl;
        ready_cnt++;
      end
      return res;
    end
    for (int i = 0; i < ready_cnt; i++) begin
      if (sched_policy == POLICY_PRIO) begin
        if (!found || ready_prio[i] > ready_prio[sel]) begin
          sel = i;
          found = 1'b1;
        end
      end else if (ready_lvl[i] != NO_LEVEL) begin
        if (!found || ready_lvl[i] < ready_lvl[sel]) begin
          sel = i;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      res.status = ST_EMPTY;
      return res;
    end
    res = '{ST_PICKED, ready_id[sel], ready_prio[sel]};
    for (int i = sel; i + 1 < ready_cnt; i++) begin
      ready_id[i]   = ready_id[i + 1];
      ready_prio[i] = ready_prio[i + 1];
      ready_lvl[i]  = ready_lvl[i + 1];
    end
    ready_cnt--;
    return res;
  endfunction

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $error("unexpected result: status %0d id %0d prio %0d", m_axis_tuser,
               m_axis_tdata[ID_W-1:0], m_axis_tdata[DATA_W-1:ID_W]);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          mismatch_count++;
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
        end
        if (m_axis_tdata[ID_W-1:0] !== want.id) begin
          mismatch_count++;
          $error("picked_id: expected %0d, got %0d", want.id, m_axis_tdata[ID_W-1:0]);
        end
        if (m_axis_tdata[DATA_W-1:ID_W] !== want.prio) begin
          mismatch_count++;
          $error("picked_priority: expected %0d, got %0d", want.prio,
                 m_axis_tdata[DATA_W-1:ID_W]);
        end
      end
    end
  end

  // Result side backpressure, switching at random between always-ready, random and periodic patterns.
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_left = 100;
  int       rx_tick = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default:   m_axis_tready <= (rx_tick % 16 >= 5);
    endcase
  end

  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_POLICY)
      sched_policy = policy_t'(val[0]);
    else if (idx >= CFG_LEVEL0 && idx <= CFG_LEVEL4)
      level_value[idx - CFG_LEVEL0] = val;
    @(posedge clk);
  endtask

  // Holds a transaction on the input channel until it is taken; valid stays high.
  task automatic offer_item(input cmd_t cmd, input logic [ID_W-1:0] tid,
                            input logic [PRIO_W-1:0] tpri);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {tpri, tid};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained(input int settle);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_level_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(0, 15));
      default: return CFG_DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  directed_row_t directed_rows[] = '{
    // Highest priority first, earliest on ties, empty list at both ends.
    '{POLICY_PRIO,  CMD_PICK,     8'h5A, 8'hA5, 1'b1, ST_EMPTY,    8'h00, 8'h00},
    '{POLICY_PRIO,  CMD_RUNNABLE, 8'h00, 8'h00, 1'b1, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_PRIO,  CMD_RUNNABLE, 8'hFF, 8'hFF, 1'b1, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_PRIO,  CMD_RUNNABLE, 8'hAA, 8'hFF, 1'b1, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_PRIO,  CMD_RUNNABLE, 8'h55, 8'h80, 1'b0, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_PRIO,  CMD_PICK,     8'h00, 8'h00, 1'b1, ST_PICKED,   8'hFF, 8'hFF},
    '{POLICY_PRIO,  CMD_PICK,     8'hFF, 8'hFF, 1'b1, ST_PICKED,   8'hAA, 8'hFF},
    '{POLICY_PRIO,  CMD_PICK,     8'h00, 8'h00, 1'b0, ST_PICKED,   8'h00, 8'h00},
    '{POLICY_PRIO,  CMD_PICK,     8'h00, 8'h00, 1'b1, ST_PICKED,   8'h00, 8'h00},
    '{POLICY_PRIO,  CMD_PICK,     8'h00, 8'h00, 1'b1, ST_EMPTY,    8'h00, 8'h00},
    // Level order; an untagged entry is never picked by level.
    '{POLICY_LEVEL, CMD_RUNNABLE, 8'h11, 8'h07, 1'b1, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_LEVEL, CMD_PICK,     8'h00, 8'h00, 1'b1, ST_EMPTY,    8'h00, 8'h00},
    '{POLICY_LEVEL, CMD_RUNNABLE, 8'h22, 8'h00, 1'b1, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_LEVEL, CMD_RUNNABLE, 8'h33, 8'h0A, 1'b1, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_LEVEL, CMD_RUNNABLE, 8'h44, 8'h0A, 1'b1, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_LEVEL, CMD_RUNNABLE, 8'h66, 8'h05, 1'b0, ST_APPENDED, 8'h00, 8'h00},
    '{POLICY_LEVEL, CMD_PICK,     8'h00, 8'h00, 1'b1, ST_PICKED,   8'h33, 8'h0A},
    '{POLICY_LEVEL, CMD_PICK,     8'h00, 8'h00, 1'b1, ST_PICKED,   8'h44, 8'h0A},
    '{POLICY_LEVEL, CMD_PICK,     8'h00, 8'h00, 1'b0, ST_PICKED,   8'h00, 8'h00},
    '{POLICY_LEVEL, CMD_PICK,     8'h00, 8'h00, 1'b1, ST_PICKED,   8'h22, 8'h00},
    '{POLICY_LEVEL, CMD_PICK,     8'h00, 8'h00, 1'b1, ST_EMPTY,    8'h00, 8'h00},
    // The untagged entry is still reachable by priority.
    '{POLICY_PRIO,  CMD_PICK,     8'h00, 8'h00, 1'b1, ST_PICKED,   8'h11, 8'h07},
    '{POLICY_PRIO,  CMD_PICK,     8'h00, 8'h00, 1'b1, ST_EMPTY,    8'h00, 8'h00}
  };

  initial begin
    sched_result_t res;
    cmd_t cmd;
    logic [ID_W-1:0] tid;
    logic [PRIO_W-1:0] tpri;
    int items_sent;
    int phase_len;
    int append_pct;
    int gap_max;
    int burst_left;
    bit last;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].pol != sched_policy) begin
        wait_drained(4);
        write_reg(CFG_POLICY, CFG_DATA_W'(directed_rows[i].pol));
      end
      offer_item(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].prio);
      res = predict_schedule(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].prio);
      if (directed_rows[i].typed)
        res = '{directed_rows[i].exp_status, directed_rows[i].exp_id, directed_rows[i].exp_prio};
      expected_results.push_back(res);
      if (i == directed_rows.size() - 1 || directed_rows[i + 1].pol != directed_rows[i].pol)
        s_axis_tvalid <= 1'b0;
    end

    // Random phases: each one waits for the block to go idle, reprograms every
    // register, then runs a stream with its own command mix and sender gaps.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_drained(4);
      write_reg(CFG_POLICY, CFG_DATA_W'($urandom_range(0, 1)));
      for (int r = CFG_LEVEL0; r <= CFG_LEVEL4; r++)
        write_reg(r, random_level_value());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(CFG_LEVEL4 + 1, 2 ** CFG_IDX_W - 1),
                  CFG_DATA_W'($urandom_range(0, 255)));

      phase_len  = $urandom_range(20, 120);
      append_pct = $urandom_range(15, 90);
      gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      for (int k = 0; k < phase_len; k++) begin
        cmd = ($urandom_range(0, 99) < append_pct) ? CMD_RUNNABLE : CMD_PICK;
        tid = ID_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0, 1:    tpri = level_value[$urandom_range(0, LEVEL_REGS - 1)];
          2:       tpri = ($urandom_range(0, 1) == 1) ? '1 : '0;
          default: tpri = PRIO_W'($urandom_range(0, 255));
        endcase
        offer_item(cmd, tid, tpri);
        expected_results.push_back(predict_schedule(cmd, tid, tpri));
        items_sent++;
        last = (k == phase_len - 1);
        if (last || (gap_max != 0 && burst_left == 0)) begin
          s_axis_tvalid <= 1'b0;
          if (!last) repeat ($urandom_range(1, gap_max)) @(posedge clk);
          burst_left = $urandom_range(1, 12);
        end else if (gap_max != 0) begin
          burst_left--;
        end
      end
    end

    wait_drained(END_SETTLE);
    if (mismatch_count == 0)
      $display("tb_dual_policy_ready_queue_scheduler passed");
    else
      $display("tb_dual_policy_ready_queue_scheduler failed");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_dual_policy_ready_queue_scheduler failed");
    $finish;
  end

endmodule
